// ----- rtl/core/sida_pkg.sv -----
package sida_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);
  localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(NUM_DIGITS - 1);

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_res_t;

endpackage

// ----- rtl/core/sida_bcd_conv.sv -----
module sida_bcd_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          neg,
  input  logic [sida_pkg::VALUE_W-1:0]  mag,
  output logic                          busy,
  output logic                          done,
  output sida_pkg::conv_res_t           res
);
  import sida_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]   sh_r, sh_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic                 neg_r, neg_nxt;
  logic [BCD_W-1:0]     bcd_adj;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = mag;
      bcd_nxt  = '0;
      neg_nxt  = neg;
    end else if (busy_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], sh_r[VALUE_W-1]};
      sh_nxt  = {sh_r[VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign res.neg = neg_r;
  assign res.bcd = bcd_r;

endmodule

// ----- rtl/core/sida_emit.sv -----
module sida_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  sida_pkg::conv_res_t           res,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sida_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_last
);
  import sida_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_SIGN,
    E_DIG
  } emit_state_t;

  emit_state_t       state_r;
  digit_t            dig_r [NUM_DIGITS];
  logic [IDX_W-1:0]  idx_r;
  logic              neg_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_character_r;
  logic              out_last_r;
  logic              can_push;
  logic              push;
  digit_t            cur_dig;

  assign can_push = !out_valid_r || !out_stall;
  assign push     = ((state_r == E_SIGN) || (state_r == E_DIG)) && can_push;
  assign cur_dig  = dig_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        E_IDLE: begin
          if (load) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
              dig_r[i] <= res.bcd[i*4 +: 4];
            end
            neg_r   <= res.neg;
            idx_r   <= TOP_IDX;
            state_r <= E_SKIP;
          end
        end
        E_SKIP: begin
          if (idx_r != '0 && cur_dig == 4'd0) begin
            idx_r <= idx_r - IDX_W'(1);
          end else if (neg_r) begin
            state_r <= E_SIGN;
          end else begin
            state_r <= E_DIG;
          end
        end
        E_SIGN: begin
          if (can_push) begin
            out_character_r <= CHAR_MINUS;
            out_last_r      <= 1'b0;
            state_r         <= E_DIG;
          end
        end
        E_DIG: begin
          if (can_push) begin
            out_character_r <= CHAR_ZERO + {4'b0000, cur_dig};
            out_last_r      <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= E_IDLE;
            end else begin
              idx_r <= idx_r - IDX_W'(1);
            end
          end
        end
        default: begin
          state_r <= E_IDLE;
        end
      endcase
    end
  end

  assign idle          = (state_r == E_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Converts one signed 32-bit request on in_value into its decimal ASCII text, one character
// per output request, most significant first, with a leading '-' for negative values and
// out_last set on the final digit. The magnitude passes through a shift-and-add-3 binary to
// BCD converter that takes the input bits in turn, most significant first, then hands over.
// The emitter then skips leading zeros at one digit per cycle, chooses the first character,
// and emits a minus sign for a negative value before the digits. While out_stall holds a
// character the emitter waits. A new request is not accepted before the previous one is
// finished: in_stall stays high until the last character has been placed in the output
// register.
module signed_int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_character,
  output logic                          out_last
);
  import sida_pkg::*;

  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic               start;
  logic               conv_busy;
  logic               conv_done;
  logic               emit_idle;
  conv_res_t          conv_res;

  assign neg      = in_value[VALUE_W-1];
  assign mag      = neg ? (VALUE_W'(0) - VALUE_W'(in_value)) : VALUE_W'(in_value);
  assign in_stall = conv_busy || conv_done || !emit_idle;
  assign start    = in_valid && !in_stall;

  sida_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .neg   (neg),
    .mag   (mag),
    .busy  (conv_busy),
    .done  (conv_done),
    .res   (conv_res)
  );

  sida_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (conv_done),
    .res           (conv_res),
    .idle          (emit_idle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
